[hw/rtl/shfd_pkg.sv]
// ----------------------------------------------------------------------------
// shfd_pkg
// Types and constants shared by the sync header frame deframer.
// ----------------------------------------------------------------------------
package shfd_pkg;

  localparam int DEF_BUFFER_DEPTH = 256;
  localparam int MAX_PAYLOAD      = 64;

  localparam logic [15:0] SYNC_WORD_RST = 16'hAA55;
  localparam logic [7:0]  CLEAR_THR_RST = 8'd200;

  // frame is sync (2), type, length, payload, checksum
  localparam int MIN_FRAME = 5;
  localparam int HDR_BYTES = 4;

  localparam int CFG_AW = 1;
  localparam int CFG_DW = 16;
  localparam logic [CFG_AW-1:0] REG_SYNC_WORD = 1'd0;
  localparam logic [CFG_AW-1:0] REG_CLEAR_THR = 1'd1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHK,
    ST_A0,
    ST_A1,
    ST_A2,
    ST_A3,
    ST_C0,
    ST_C1,
    ST_E0,
    ST_E1,
    ST_FIN,
    ST_END
  } state_t;

endpackage

[hw/rtl/shfd_ram.sv]
// ----------------------------------------------------------------------------
// shfd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module shfd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hw/rtl/sync_header_frame_deframer.sv]
// ----------------------------------------------------------------------------
// sync_header_frame_deframer
// Byte stream deframer: sync word, type, length, payload, XOR checksum.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one received byte per request (tdata[7:0]).
//   out_* : one result per payload byte of an accepted frame, or a single
//           result for an empty or oversized payload; tlast marks the last.
//   cfg_* : write sync word (index 0) and clear threshold (index 1) while idle.
// Bytes sit in a circular buffer RAM (one read port, registered data). After
// each byte the sequencer rescans from the oldest byte: two reads per sync
// compare, a length read, then a read and an XOR step (C0, C1) per
// checksummed byte and a read and an output step (E0, E1) per emitted
// payload byte. in_tready is high only while idle, so no new byte is taken
// while a rescan runs.
// Results sit in an output register; a stalled receiver holds the sequencer
// before the next result is loaded, and the next byte may be taken while the
// final result of a frame still waits. Reset empties the buffer at once (fill
// count and head pointer only) and loads the register defaults.
// ----------------------------------------------------------------------------
module sync_header_frame_deframer
  import shfd_pkg::*;
#(
  parameter int BUFFER_DEPTH = DEF_BUFFER_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [7:0]        in_tdata,   // rx_byte
  output logic              out_tvalid,
  input  logic              out_tready,
  // frame_type[7:0], payload_length[15:8], payload_present[16],
  // payload_byte[24:17], byte_index[30:25], zero[31]
  output logic [31:0]       out_tdata,
  output logic              out_tlast,
  input  logic              cfg_wr_en,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [CFG_DW-1:0] cfg_wdata
);

  localparam int AW = $clog2(BUFFER_DEPTH);
  localparam int FW = $clog2(BUFFER_DEPTH + 1);
  localparam int SW = ((FW > 8) ? FW : 8) + 2;

  state_t state_r, state_nxt;

  logic [15:0]   sync_r;
  logic [7:0]    thr_r;
  logic [FW-1:0] fill_r, fill_nxt;
  logic [AW-1:0] head_r, head_nxt;
  logic [SW-1:0] pos_r, pos_nxt;
  logic [8:0]    k_r, k_nxt;
  logic [7:0]    b0_r, b0_nxt;
  logic [7:0]    len_r, len_nxt;
  logic [7:0]    type_r, type_nxt;
  logic [7:0]    cs_r, cs_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [31:0]   out_data_r, out_data_nxt;
  logic          out_last_r, out_last_nxt;

  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [7:0]    ram_rdata;
  logic [SW-1:0] rd_off;
  logic [SW-1:0] fill_ext;
  logic [SW-1:0] frame_end;
  logic          in_acc, slot_free, empty_pl, last_res;

  function automatic logic [AW-1:0] phys(input logic [AW-1:0] head,
                                         input logic [SW-1:0] off);
    logic [AW+1:0] s;
    s = {2'b00, head} + (AW+2)'(off[AW:0]);
    if (s >= (AW+2)'(BUFFER_DEPTH)) begin
      s = s - (AW+2)'(BUFFER_DEPTH);
    end
    return s[AW-1:0];
  endfunction

  shfd_ram #(
    .WIDTH (8),
    .DEPTH (BUFFER_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_tdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_tready  = (state_r == ST_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  assign fill_ext  = SW'(fill_r);
  assign frame_end = pos_r + SW'(MIN_FRAME) + SW'(len_r);
  assign slot_free = !out_valid_r || out_tready;
  assign empty_pl  = (len_r == 8'd0) || (len_r > 8'(MAX_PAYLOAD));
  assign last_res  = empty_pl || ((k_r + 9'd1) == {1'b0, len_r});

  // append the new byte behind the newest one unless full
  assign ram_we    = in_acc && (fill_ext < SW'(BUFFER_DEPTH));
  assign ram_waddr = phys(head_r, fill_ext);
  assign ram_raddr = phys(head_r, rd_off);

  always_comb begin
    case (state_r)
      ST_A1:   rd_off = pos_r + SW'(1);
      ST_A2:   rd_off = pos_r + SW'(3);
      ST_C0:   rd_off = pos_r + SW'(k_r);
      ST_E0,
      ST_E1:   rd_off = pos_r + SW'(HDR_BYTES) + SW'(k_r);
      default: rd_off = pos_r;
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_acc) state_nxt = ST_CHK;
      ST_CHK:  state_nxt = (fill_ext >= SW'(MIN_FRAME)) ? ST_A0 : ST_END;
      ST_A0:   state_nxt = (pos_r + SW'(HDR_BYTES) > fill_ext) ? ST_END : ST_A1;
      ST_A1:   state_nxt = ST_A2;
      ST_A2:   state_nxt = ({ram_rdata, b0_r} == sync_r) ? ST_A3 : ST_A0;
      ST_A3: begin
        if (pos_r + SW'(MIN_FRAME) + SW'(ram_rdata) > fill_ext) begin
          state_nxt = ST_END;
        end else begin
          state_nxt = ST_C0;
        end
      end
      ST_C0:   state_nxt = ST_C1;
      ST_C1: begin
        if (k_r == 9'(HDR_BYTES) + {1'b0, len_r}) begin
          state_nxt = (cs_r == ram_rdata) ? ST_E0 : ST_A0;
        end else begin
          state_nxt = ST_C0;
        end
      end
      ST_E0:   state_nxt = ST_E1;
      ST_E1: begin
        if (slot_free) state_nxt = last_res ? ST_FIN : ST_E0;
      end
      ST_FIN:  state_nxt = ST_IDLE;
      ST_END:  state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath
  always_comb begin
    fill_nxt      = fill_r;
    head_nxt      = head_r;
    pos_nxt       = pos_r;
    k_nxt         = k_r;
    b0_nxt        = b0_r;
    len_nxt       = len_r;
    type_nxt      = type_r;
    cs_nxt        = cs_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;
    case (state_r)
      ST_IDLE: if (ram_we) fill_nxt = fill_r + FW'(1);
      ST_CHK:  pos_nxt = '0;
      ST_A1:   b0_nxt = ram_rdata;
      ST_A2:   if ({ram_rdata, b0_r} != sync_r) pos_nxt = pos_r + SW'(1);
      ST_A3: begin
        len_nxt = ram_rdata;
        k_nxt   = '0;
        cs_nxt  = '0;
      end
      ST_C1: begin
        if (k_r == 9'(HDR_BYTES) + {1'b0, len_r}) begin
          k_nxt = '0;
          // bad checksum: resume the hunt one byte later
          if (cs_r != ram_rdata) pos_nxt = pos_r + SW'(1);
        end else begin
          cs_nxt = cs_r ^ ram_rdata;
          if (k_r == 9'd2) type_nxt = ram_rdata;
          k_nxt = k_r + 9'd1;
        end
      end
      ST_E1: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_last_nxt  = last_res;
          out_data_nxt  = {1'b0,
                           empty_pl ? 6'd0 : k_r[5:0],
                           empty_pl ? 8'd0 : ram_rdata,
                           !empty_pl,
                           len_r,
                           type_r};
          k_nxt = k_r + 9'd1;
        end
      end
      ST_FIN: begin
        // drop everything through the checksum byte
        head_nxt = phys(head_r, frame_end);
        fill_nxt = fill_r - FW'(frame_end);
      end
      ST_END: begin
        if (fill_ext > SW'(thr_r)) begin
          fill_nxt = '0;
          head_nxt = '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      sync_r      <= SYNC_WORD_RST;
      thr_r       <= CLEAR_THR_RST;
      fill_r      <= '0;
      head_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      head_r      <= head_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        case (cfg_addr)
          REG_SYNC_WORD: sync_r <= cfg_wdata;
          REG_CLEAR_THR: thr_r  <= cfg_wdata[7:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    pos_r      <= pos_nxt;
    k_r        <= k_nxt;
    b0_r       <= b0_nxt;
    len_r      <= len_nxt;
    type_r     <= type_nxt;
    cs_r       <= cs_nxt;
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FW'(BUFFER_DEPTH))
    else $error("fill count beyond buffer depth");

  a_empty_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_data_r[16] |-> out_last_r && (out_data_r[30:25] == 6'd0))
    else $error("empty payload result is not a single last item");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_tready |=> $stable(out_data_r) && $stable(out_last_r))
    else $error("pending result overwritten");

endmodule

[tb/tb_sync_header_frame_deframer.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sync_header_frame_deframer
// Self-checking bench for the sync header frame deframer. A short table of
// directed bytes is followed by random frames (good, bad checksum, truncated,
// oversized) mixed with noise, under several sync word and clear threshold
// settings. Every accepted byte is fed through a local frame predictor and
// every result is compared, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_sync_header_frame_deframer;
  import shfd_pkg::*;

  localparam int DEPTH     = DEF_BUFFER_DEPTH;
  localparam int DRAIN     = 20000;
  localparam int LIMIT     = 3000000;
  localparam int LONG_HOLD = 2500;

  typedef struct packed {
    logic [7:0] frm_type;
    logic [7:0] plen;
    logic       present;
    logic [7:0] data;
    logic [5:0] idx;
    logic       lst;
  } frame_res_t;

  typedef struct {
    logic [7:0] b;
    bit         chk;
    logic [31:0] word;
    bit         lst;
  } dir_row_t;

  logic              clk;
  logic              rst_n;
  logic              in_tvalid;
  logic              in_tready;
  logic [7:0]        in_tdata;   // rx_byte
  logic              out_tvalid;
  logic              out_tready;
  // frame_type[7:0], payload_length[15:8], payload_present[16],
  // payload_byte[24:17], byte_index[30:25], zero[31]
  logic [31:0]       out_tdata;
  logic              out_tlast;
  logic              cfg_wr_en;
  logic [CFG_AW-1:0] cfg_addr;
  logic [CFG_DW-1:0] cfg_wdata;

  sync_header_frame_deframer dut (.*);

  // predictor state
  logic [7:0]  rx_store [DEPTH];
  int          rx_fill;
  logic [15:0] sync_cfg;
  logic [7:0]  clr_thr;
  frame_res_t  pending_q[$];

  int  errors, n_bytes, n_results, n_frames, cycles;
  bit  in_gaps, out_gaps, hold_done;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    errors++;
    $display("[%0t] mismatch %s: got %h want %h", $realtime, what, got, want);
  endtask

  // Work out the results of one accepted byte and update the buffer copy.
  task automatic deframe_byte(input logic [7:0] b);
    int pos, flen, len, fill, endp;
    logic [7:0] cs;
    bit found;
    frame_res_t r;
    found = 0;
    flen = 0;
    pos = 0;
    if (rx_fill < DEPTH) begin
      rx_store[rx_fill] = b;
      rx_fill++;
    end
    fill = rx_fill;
    if (fill >= MIN_FRAME) begin
      for (pos = 0; pos + HDR_BYTES <= fill; pos++) begin
        if ({rx_store[pos+1], rx_store[pos]} != sync_cfg) continue;
        len = rx_store[pos+3];
        flen = MIN_FRAME + len;
        if (pos + flen > fill) break;
        cs = 0;
        for (int k = 0; k < HDR_BYTES + len; k++) cs ^= rx_store[pos+k];
        if (cs == rx_store[pos+HDR_BYTES+len]) begin
          found = 1;
          break;
        end
      end
    end
    if (found) begin
      len = rx_store[pos+3];
      r.frm_type = rx_store[pos+2];
      r.plen = len[7:0];
      if (len == 0 || len > MAX_PAYLOAD) begin
        r.present = 0; r.data = 0; r.idx = 0; r.lst = 1;
        pending_q.push_back(r);
      end else begin
        for (int k = 0; k < len; k++) begin
          r.present = 1;
          r.data = rx_store[pos+HDR_BYTES+k];
          r.idx = k[5:0];
          r.lst = (k + 1 == len);
          pending_q.push_back(r);
        end
      end
      endp = pos + flen;
      rx_fill = fill - endp;
      for (int k = 0; k < rx_fill; k++) rx_store[k] = rx_store[endp+k];
    end else if (fill > clr_thr) begin
      rx_fill = 0;
    end
  endtask

  task automatic put_byte(input logic [7:0] b);
    int gap;
    gap = in_gaps ? $urandom_range(0, 7) : 0;
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    do @(posedge clk); while (!in_tready);
    n_bytes++;
    deframe_byte(b);
  endtask

  // Hold until every prediction has arrived and the rescan has finished.
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_AW-1:0] a, input logic [CFG_DW-1:0] d);
    cfg_wr_en <= 1'b1;
    cfg_addr  <= a;
    cfg_wdata <= d;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    if (a == REG_SYNC_WORD) sync_cfg = d;
    else clr_thr = d[7:0];
    @(posedge clk);
  endtask

  // One random frame: good, bad checksum, truncated, oversized, or noise.
  task automatic send_frame(input int len_max, input bit big_ok);
    logic [7:0] q[$];
    logic [7:0] cs;
    int len, kind;
    kind = $urandom_range(0, 99);
    if (kind < 12) begin
      repeat ($urandom_range(1, 4)) put_byte(8'($urandom));
      return;
    end
    len = $urandom_range(0, len_max);
    if (big_ok && kind >= 95) len = $urandom_range(MAX_PAYLOAD + 1, MAX_PAYLOAD + 6);
    q.push_back(sync_cfg[7:0]);
    q.push_back(sync_cfg[15:8]);
    q.push_back(8'($urandom));
    q.push_back(len[7:0]);
    repeat (len) q.push_back(8'($urandom));
    cs = 0;
    foreach (q[i]) cs ^= q[i];
    if (kind < 22) cs ^= 8'(1 << $urandom_range(0, 7));
    q.push_back(cs);
    if (kind >= 22 && kind < 26) q = q[0:$urandom_range(2, q.size() - 2)];
    foreach (q[i]) put_byte(q[i]);
  endtask

  task automatic random_phase(input int quota, input int len_max, input bit big_ok);
    int stop;
    stop = n_bytes + quota;
    while (n_bytes < stop) send_frame(len_max, big_ok);
  endtask

  // result checker and receiver stalls
  initial begin
    frame_res_t want, got;
    int gap;
    out_tready <= 1'b0;
    @(posedge rst_n);
    out_tready <= 1'b1;
    forever begin
      @(posedge clk);
      if (out_tvalid && out_tready) begin
        got.frm_type = out_tdata[7:0];
        got.plen     = out_tdata[15:8];
        got.present  = out_tdata[16];
        got.data     = out_tdata[24:17];
        got.idx      = out_tdata[30:25];
        got.lst      = out_tlast;
        n_results++;
        if (out_tlast) n_frames++;
        if (pending_q.size() == 0) begin
          report("unexpected result", {out_tdata[30:0], out_tlast}, 32'h0);
        end else begin
          want = pending_q.pop_front();
          if (got.frm_type != want.frm_type)
            report("frame_type", 32'(got.frm_type), 32'(want.frm_type));
          if (got.plen != want.plen)
            report("payload_length", 32'(got.plen), 32'(want.plen));
          if (got.present != want.present)
            report("payload_present", 32'(got.present), 32'(want.present));
          if (got.data != want.data)
            report("payload_byte", 32'(got.data), 32'(want.data));
          if (got.idx != want.idx)
            report("byte_index", 32'(got.idx), 32'(want.idx));
          if (got.lst != want.lst)
            report("last", 32'(got.lst), 32'(want.lst));
        end
        gap = out_gaps ? $urandom_range(0, 7) : 0;
        if (!hold_done && n_results == 12) begin
          gap = LONG_HOLD;
          hold_done = 1;
        end
        if (gap != 0) begin
          out_tready <= 1'b0;
          repeat (gap) @(posedge clk);
          out_tready <= 1'b1;
        end
      end
    end
  end

  initial begin
    dir_row_t dir_tab[$];
    frame_res_t last_pred;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    cfg_wr_en = 1'b0;
    cfg_addr = '0;
    cfg_wdata = '0;
    sync_cfg = SYNC_WORD_RST;
    clr_thr = CLEAR_THR_RST;
    rx_fill = 0;
    in_gaps = 1;
    out_gaps = 1;

    // empty payload, leading garbage before a one-byte frame, bad checksum
    // then a resumed hunt, and the extreme byte values
    dir_tab = '{
      '{8'h55, 0, 0, 0}, '{8'hAA, 0, 0, 0}, '{8'h7E, 0, 0, 0}, '{8'h00, 0, 0, 0},
      '{8'h81, 1, 32'h0000_007E, 1},
      '{8'hFF, 0, 0, 0}, '{8'h55, 0, 0, 0}, '{8'hAA, 0, 0, 0}, '{8'h01, 0, 0, 0},
      '{8'h01, 0, 0, 0}, '{8'h00, 0, 0, 0},
      '{8'hFF, 1, 32'h0001_0101, 1},
      '{8'h55, 0, 0, 0}, '{8'hAA, 0, 0, 0}, '{8'h02, 0, 0, 0}, '{8'h01, 0, 0, 0},
      '{8'h33, 0, 0, 0}, '{8'h00, 0, 0, 0},
      '{8'h55, 0, 0, 0}, '{8'hAA, 0, 0, 0}, '{8'hFF, 0, 0, 0}, '{8'h01, 0, 0, 0},
      '{8'hFF, 0, 0, 0}, '{8'hFE, 1, 32'h01FF_01FF, 1}
    };

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tab[i]) begin
      put_byte(dir_tab[i].b);
      if (dir_tab[i].chk) begin
        last_pred = pending_q.size() ? pending_q[$] : '0;
        if ({1'b0, last_pred.idx, last_pred.data, last_pred.present,
             last_pred.plen, last_pred.frm_type} != dir_tab[i].word ||
            last_pred.lst != dir_tab[i].lst)
          report("directed frame", {1'b0, last_pred.idx, last_pred.data,
                 last_pred.present, last_pred.plen, last_pred.frm_type}, dir_tab[i].word);
      end
    end

    random_phase(80, 8, 0);
    // one maximal payload frame under the reset settings
    random_phase(1, 0, 0);
    begin
      logic [7:0] q[$];
      logic [7:0] cs;
      q = '{sync_cfg[7:0], sync_cfg[15:8], 8'($urandom), 8'(MAX_PAYLOAD)};
      repeat (MAX_PAYLOAD) q.push_back(8'($urandom));
      cs = 0;
      foreach (q[i]) cs ^= q[i];
      q.push_back(cs);
      foreach (q[i]) put_byte(q[i]);
    end
    wait_idle();

    write_reg(REG_SYNC_WORD, 16'hFFFF);
    write_reg(REG_CLEAR_THR, 16'd254);
    out_gaps = 0;
    random_phase(25, 12, 1);
    wait_idle();

    // threshold of one: the buffer never holds enough for a frame
    write_reg(REG_SYNC_WORD, 16'h0000);
    write_reg(REG_CLEAR_THR, 16'd1);
    in_gaps = 0;
    out_gaps = 1;
    random_phase(12, 3, 0);
    wait_idle();

    write_reg(REG_SYNC_WORD, 16'h3C96);
    write_reg(REG_CLEAR_THR, 16'd30);
    in_gaps = 1;
    random_phase(20, 10, 0);
    wait_idle();

    while (pending_q.size() != 0) begin
      frame_res_t r;
      r = pending_q.pop_front();
      report("missing result", 32'h0,
             {1'b0, r.idx, r.data, r.present, r.plen, r.frm_type});
    end
    $display("Sent %0d bytes under four sync/threshold settings; %0d results in %0d frames.",
             n_bytes, n_results, n_frames);
    $display("Covered empty, oversized, bad-checksum, truncated frames and a long stall.");
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
